// File: sv/dukpt_session_key_derivation_macros.svh
// assertion macros for the key derivation block
`ifndef DUKPT_SESSION_KEY_DERIVATION_MACROS_SVH
`define DUKPT_SESSION_KEY_DERIVATION_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define DKD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define DKD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/dkd_pkg.sv
package dkd_pkg;

  localparam int KeyW = 64;
  localparam int TypeW = 3;
  localparam int CntW = 21;
  localparam logic [KeyW-1:0] BaseMask = 64'hFFFF_FFFF_FFE0_0000;
  localparam logic [KeyW-1:0] C0c0Half = 64'hC0C0_C0C0_0000_0000;

  localparam logic [TypeW-1:0] KtDerived = 3'd0;
  localparam logic [TypeW-1:0] KtPin = 3'd1;
  localparam logic [TypeW-1:0] KtMacReq = 3'd2;
  localparam logic [TypeW-1:0] KtMacRsp = 3'd3;
  localparam logic [TypeW-1:0] KtDataReq = 3'd4;
  localparam logic [TypeW-1:0] KtDataRsp = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STEP_R,
    ST_STEP_L,
    ST_MASK,
    ST_TDES,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic decrypt;
  } des_ctl_t;

  typedef logic [7:0] tab_t [64];

  localparam tab_t TIp = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam tab_t TFp = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam logic [7:0] TE [48] = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam logic [7:0] TP [32] = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam logic [7:0] TPc1 [56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,60,52,44,36,
    63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
  localparam logic [7:0] TPc2 [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam logic [15:0] TRotOne = 16'b1000_0001_0000_0011;

  localparam logic [3:0] TS [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-TIp[i]];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-TFp[i]];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64-TPc1[i]];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56-TPc2[i]];
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] e;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0] six;
    for (int i = 0; i < 48; i++) e[47-i] = r[32-TE[i]];
    e = e ^ k;
    for (int i = 0; i < 8; i++) begin
      six = e[47-6*i -: 6];
      s[31-4*i -: 4] = TS[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-TP[i]];
    return p;
  endfunction

  function automatic logic [27:0] rotl(input logic [27:0] v, input logic one);
    return one ? {v[26:0], v[27]} : {v[25:0], v[27:26]};
  endfunction

  function automatic logic [27:0] rotr(input logic [27:0] v, input logic one);
    return one ? {v[0], v[27:1]} : {v[1:0], v[27:2]};
  endfunction

endpackage

// File: sv/dkd_des_core.sv
module dkd_des_core (
  input  logic              clk,
  input  logic              rst,
  input  dkd_pkg::des_ctl_t ctl,
  input  logic [63:0]       key,
  input  logic [63:0]       blk,
  output logic              done,
  output logic [63:0]       result
);
  import dkd_pkg::*;

  logic        busy;
  logic        dec;
  logic [3:0]  rnd;
  logic [27:0] c;
  logic [27:0] d;
  logic [31:0] l;
  logic [31:0] r;
  logic [27:0] c_use;
  logic [27:0] d_use;
  logic [55:0] cd0;
  logic [63:0] ip;
  logic        one;

  assign cd0 = perm_pc1(key);
  assign ip = perm_ip(blk);
  assign one = TRotOne[rnd];
  // encrypt rotates before use; decrypt uses then rotates right
  assign c_use = dec ? c : rotl(c, one);
  assign d_use = dec ? d : rotl(d, one);
  assign result = perm_fp({r, l});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd <= '0;
    end else begin
      done <= !ctl.start && busy && (rnd == 4'd15);
      if (ctl.start) begin
        busy <= 1'b1;
        dec <= ctl.decrypt;
        rnd <= '0;
        c <= cd0[55:28];
        d <= cd0[27:0];
        l <= ip[63:32];
        r <= ip[31:0];
      end else if (busy) begin
        l <= r;
        r <= l ^ feistel(r, perm_pc2({c_use, d_use}));
        if (dec) begin
          c <= rotr(c, TRotOne[4'd15 - rnd]);
          d <= rotr(d, TRotOne[4'd15 - rnd]);
        end else begin
          c <= c_use;
          d <= d_use;
        end
        rnd <= rnd + 4'd1;
        if (rnd == 4'd15) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

// File: sv/dukpt_session_key_derivation.sv
// dukpt tdes session key derivation
// s_axis: one transaction carries the initial key, the low ksn word and key type
// m_axis: one transaction carries the resulting 128-bit key
// every input transaction gives exactly one output transaction
// one des core runs one round per cycle; each des holds the sequencer through its
// start, 16 rounds and done
// each set counter bit costs two des runs; data key types add six more
// s_tready is high only while idle; one item is in work at a time
// the next transaction can be taken in the cycle after the output transaction
// the result stays in the output register until m_tready takes it
// while the receiver stalls no new item is accepted
// reset returns the sequencer to idle and drops m_tvalid
module dukpt_session_key_derivation (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // ipek_left[63:0], ipek_right[127:64], ksn_low[191:128]
  input  logic [191:0] s_tdata,
  // key_type[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // key_left[63:0], key_right[127:64]
  output logic [127:0] m_tdata
);
  import dkd_pkg::*;

  state_t      state, state_next;
  logic [63:0] kl, kr, base;
  logic [CntW-1:0] ksn;
  logic [63:0] nr;
  logic [TypeW-1:0] ktype;
  logic [4:0]  bitn;
  logic [2:0]  phase;
  logic        pending;
  logic        wait_des;
  logic [63:0] el;
  des_ctl_t    ctl;
  logic [63:0] dkey, dblk, dres;
  logic        ddone;
  logic [63:0] mask;

  dkd_des_core u_des (
    .clk(clk), .rst(rst), .ctl(ctl), .key(dkey), .blk(dblk),
    .done(ddone), .result(dres)
  );

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_DONE);
  assign m_tdata = {kr, kl};

  always_comb begin
    case (ktype)
      KtPin:     mask = 64'h0000_0000_0000_00FF;
      KtMacReq:  mask = 64'h0000_0000_0000_FF00;
      KtMacRsp:  mask = 64'h0000_0000_FF00_0000;
      KtDataReq: mask = 64'h0000_0000_00FF_0000;
      KtDataRsp: mask = 64'h0000_00FF_0000_0000;
      default:   mask = '0;
    endcase
  end

  // tdes phases: 0..2 on left half, 3..5 on right half
  always_comb begin
    ctl = '0;
    dkey = kl;
    dblk = base ^ kr;
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_SCAN;
      ST_SCAN: begin
        if (ksn[bitn]) state_next = ST_STEP_R;
        else if (bitn == 5'd0) state_next = ST_MASK;
      end
      ST_STEP_R: begin
        ctl.start = !wait_des;
        if (ddone) state_next = ST_STEP_L;
      end
      ST_STEP_L: begin
        ctl.start = !wait_des;
        dkey = kl ^ C0c0Half;
        dblk = base ^ kr ^ C0c0Half;
        if (ddone) state_next = (bitn == 5'd0) ? ST_MASK : ST_SCAN;
      end
      ST_MASK: begin
        if (ktype == KtDataReq || ktype == KtDataRsp) state_next = ST_TDES;
        else state_next = ST_DONE;
      end
      ST_TDES: begin
        ctl.start = !wait_des;
        ctl.decrypt = (phase == 3'd1) || (phase == 3'd4);
        dkey = ctl.decrypt ? kr : kl;
        dblk = pending ? el : ((phase < 3'd3) ? kl : kr);
        if (ddone && phase == 3'd5) state_next = ST_DONE;
      end
      ST_DONE: if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wait_des <= 1'b0;
      pending <= 1'b0;
      phase <= '0;
      bitn <= '0;
    end else begin
      state <= state_next;
      if (ctl.start) wait_des <= 1'b1;
      if (ddone) wait_des <= 1'b0;
      case (state)
        ST_IDLE: if (s_tvalid) begin
          kl <= s_tdata[63:0];
          kr <= s_tdata[127:64];
          ksn <= s_tdata[148:128];
          base <= s_tdata[191:128] & BaseMask;
          ktype <= s_tuser;
          bitn <= 5'd20;
        end
        ST_SCAN: begin
          if (ksn[bitn]) base[bitn] <= 1'b1;
          else if (bitn != 5'd0) bitn <= bitn - 5'd1;
        end
        ST_STEP_R: if (ddone) nr <= dres ^ kr;
        ST_STEP_L: if (ddone) begin
          kl <= dres ^ kr ^ C0c0Half;
          kr <= nr;
          if (bitn != 5'd0) bitn <= bitn - 5'd1;
        end
        ST_MASK: begin
          kl <= kl ^ mask;
          kr <= kr ^ mask;
          phase <= '0;
          pending <= 1'b0;
        end
        ST_TDES: if (ddone) begin
          el <= dres;
          if (phase == 3'd2) begin
            nr <= dres;
            pending <= 1'b0;
          end else if (phase == 3'd5) begin
            kl <= nr;
            kr <= dres;
          end else begin
            pending <= 1'b1;
          end
          phase <= phase + 3'd1;
        end
        default: ;
      endcase
    end
  end
endmodule

// File: sv/dkd_checker.sv
`include "dukpt_session_key_derivation_macros.svh"
module dkd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);
  `DKD_ASSERT_IMP(a_no_overlap, clk, rst, m_tvalid, !s_tready)
  `DKD_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `DKD_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `DKD_ASSERT_NEXT(a_no_instant_out, clk, rst, s_tvalid && s_tready, !m_tvalid)
endmodule

bind dukpt_session_key_derivation dkd_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
